[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDSE_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdse check failed: same-cycle condition violated");

// The consequent must hold in the cycle after the antecedent.
`define BDSE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdse check failed: next-cycle condition violated");

`endif

[rtl/bdse_pkg.sv]
`default_nettype none

package bdse_pkg;

   localparam int CODE_W    = 8;
   localparam int POS_W     = 15;
   localparam int DIST_W    = 16;
   localparam int ACC_W     = 18;
   localparam int CLK_W     = 16;
   localparam int QUO_W     = 17;
   localparam int DIR_W     = 2;
   localparam int CMD_W     = 2;
   localparam int DIV_STEPS = QUO_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
   localparam int Q_DEPTH   = 4;
   localparam int Q_AW      = $clog2(Q_DEPTH);
   localparam int CSR_IDX_W = 3;

   localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MOTION  = 2'd2;

   // Wheel direction codes: NEG is up or left, POS is down or right.
   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_NEG  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_POS  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_CODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOGGLE_MODE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAP_MODE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_DIR      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_START_DIST = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HORZ_START_DIST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_STEP       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HORZ_STEP       = 3'd7;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_LOAD   = 2'd1,
      OP_SCROLL = 2'd2
   } op_type;

   typedef struct packed {
      logic [CODE_W-1:0] trigger_code;
      logic              toggle_mode;
      logic              trap_mode;
      logic              invert_dir;
      logic [DIST_W-1:0] vert_start_dist;
      logic [DIST_W-1:0] horz_start_dist;
      logic [DIST_W-1:0] vert_step;
      logic [DIST_W-1:0] horz_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      trigger_code:    8'd2,
      toggle_mode:     1'b0,
      trap_mode:       1'b0,
      invert_dir:      1'b0,
      vert_start_dist: 16'd10,
      horz_start_dist: 16'd10,
      vert_step:       16'd10,
      horz_step:       16'd50
   };

   typedef struct packed {
      logic [POS_W-1:0] moved;
      logic [DIR_W-1:0] dir;
   } axis_move_type;

   typedef struct packed {
      op_type           op;
      axis_move_type    vert;
      axis_move_type    horz;
      logic             warp;
      logic [POS_W-1:0] warp_x;
      logic [POS_W-1:0] warp_y;
   } job_type;

endpackage

`default_nettype wire

[rtl/bdse_fifo.sv]
`default_nettype none

module bdse_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bdse_pkg::job_type din,
   output logic                   full,
   input  wire logic              pop,
   output bdse_pkg::job_type      dout,
   output logic                   empty
);
   import bdse_pkg::*;

   job_type           mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == (Q_AW + 1)'(Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

[rtl/bdse_front.sv]
`default_nettype none

module bdse_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bdse_pkg::cfg_type          cfg,
   input  wire logic                       req_push,
   input  wire logic [bdse_pkg::CMD_W-1:0] req_command,
   input  wire logic [bdse_pkg::CODE_W-1:0] req_code,
   input  wire logic [bdse_pkg::POS_W-1:0] req_pos_x,
   input  wire logic [bdse_pkg::POS_W-1:0] req_pos_y,
   input  wire logic                       q_full,
   output logic                            q_push,
   output bdse_pkg::job_type               q_data
);
   import bdse_pkg::*;

   logic             active_ff, active_in;
   logic [POS_W-1:0] anchor_x_ff, anchor_x_in;
   logic [POS_W-1:0] anchor_y_ff, anchor_y_in;
   logic [POS_W-1:0] prev_x_ff, prev_x_in;
   logic [POS_W-1:0] prev_y_ff, prev_y_in;
   logic             accept;
   logic             trig;
   logic             off_anchor;

   function automatic axis_move_type calc_move(input logic [POS_W-1:0] from_pos,
                                               input logic [POS_W-1:0] to_pos,
                                               input logic inv);
      axis_move_type res;
      res.moved = '0;
      res.dir   = DIR_NONE;
      if (to_pos < from_pos) begin
         res.moved = from_pos - to_pos;
         res.dir   = inv ? DIR_POS : DIR_NEG;
      end else if (to_pos > from_pos) begin
         res.moved = to_pos - from_pos;
         res.dir   = inv ? DIR_NEG : DIR_POS;
      end
      return res;
   endfunction

   assign accept     = req_push && !q_full;
   assign trig       = (req_code == cfg.trigger_code);
   assign off_anchor = (req_pos_x != anchor_x_ff) || (req_pos_y != anchor_y_ff);
   assign q_push     = accept;

   always_comb begin
      active_in   = active_ff;
      anchor_x_in = anchor_x_ff;
      anchor_y_in = anchor_y_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      q_data      = '0;
      q_data.op   = OP_NONE;
      case (req_command)
         CMD_PRESS: begin
            if (trig) begin
               anchor_x_in = req_pos_x;
               anchor_y_in = req_pos_y;
               active_in   = cfg.toggle_mode ? !active_ff : 1'b1;
               q_data.op   = OP_LOAD;
            end
         end
         CMD_RELEASE: begin
            if (trig && !cfg.toggle_mode) begin
               active_in = 1'b0;
            end
         end
         CMD_MOTION: begin
            prev_x_in = req_pos_x;
            prev_y_in = req_pos_y;
            if (active_ff && off_anchor) begin
               q_data.op   = OP_SCROLL;
               q_data.vert = calc_move(prev_y_ff, req_pos_y, cfg.invert_dir);
               q_data.horz = calc_move(prev_x_ff, req_pos_x, cfg.invert_dir);
               if (cfg.trap_mode) begin
                  q_data.warp   = 1'b1;
                  q_data.warp_x = anchor_x_ff;
                  q_data.warp_y = anchor_y_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
      end else if (accept) begin
         active_ff   <= active_in;
         anchor_x_ff <= anchor_x_in;
         anchor_y_ff <= anchor_y_in;
         prev_x_ff   <= prev_x_in;
         prev_y_ff   <= prev_y_in;
      end
   end

endmodule

`default_nettype wire

[rtl/bdse_div.sv]
`default_nettype none

module bdse_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [bdse_pkg::QUO_W-1:0]  dividend,
   input  wire logic [bdse_pkg::DIST_W-1:0] divisor,
   output logic                             busy,
   output logic [bdse_pkg::QUO_W-1:0]       quotient,
   output logic [bdse_pkg::DIST_W-1:0]      remainder
);
   import bdse_pkg::*;

   logic              busy_ff, busy_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DIST_W-1:0] rem_ff, rem_in;
   logic [DIST_W-1:0] div_ff, div_in;
   logic [DIST_W:0]   rem_sh;
   logic [DIST_W:0]   diff;
   logic              ge;

   // Restoring division: one quotient bit per cycle, dividend shifted out of
   // the top of the quotient register as quotient bits enter at the bottom.
   assign rem_sh = {rem_ff, quo_ff[QUO_W-1]};
   assign ge     = (rem_sh >= {1'b0, div_ff});
   assign diff   = rem_sh - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[QUO_W-2:0], ge};
         rem_in = ge ? diff[DIST_W-1:0] : rem_sh[DIST_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[rtl/bdse_back.sv]
`default_nettype none

module bdse_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bdse_pkg::cfg_type            cfg,
   input  wire logic                         q_empty,
   input  wire bdse_pkg::job_type            q_data,
   output logic                              q_pop,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic [bdse_pkg::DIR_W-1:0]        rsp_vert_dir,
   output logic [bdse_pkg::CLK_W-1:0]        rsp_vert_clicks,
   output logic [bdse_pkg::DIR_W-1:0]        rsp_horz_dir,
   output logic [bdse_pkg::CLK_W-1:0]        rsp_horz_clicks,
   output logic                              rsp_warp_request,
   output logic [bdse_pkg::POS_W-1:0]        rsp_warp_x,
   output logic [bdse_pkg::POS_W-1:0]        rsp_warp_y
);
   import bdse_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PREP  = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   typedef struct packed {
      logic [ACC_W-1:0] acc;
      logic [CLK_W-1:0] clicks;
      logic [DIR_W-1:0] dir;
   } axis_res_type;

   state_type               state_ff, state_in;
   job_type                 job_ff, job_in;
   logic signed [ACC_W-1:0] va_ff, va_in;
   logic signed [ACC_W-1:0] ha_ff, ha_in;
   logic signed [ACC_W-1:0] vacc_ff, vacc_in;
   logic signed [ACC_W-1:0] hacc_ff, hacc_in;
   logic                    out_valid_ff, out_valid_in;
   logic [DIR_W-1:0]        vdir_ff, vdir_in;
   logic [CLK_W-1:0]        vclk_ff, vclk_in;
   logic [DIR_W-1:0]        hdir_ff, hdir_in;
   logic [CLK_W-1:0]        hclk_ff, hclk_in;
   logic                    warp_ff, warp_in;
   logic [POS_W-1:0]        wx_ff, wx_in;
   logic [POS_W-1:0]        wy_ff, wy_in;

   logic [DIST_W-1:0]       vstep, hstep;
   logic signed [ACC_W-1:0] vdiv_arg, hdiv_arg;
   logic                    div_start;
   logic                    vbusy, hbusy;
   logic [QUO_W-1:0]        vquo, hquo;
   logic [DIST_W-1:0]       vrem, hrem;
   axis_res_type            vres, hres;

   // A step register of zero counts as a step of one.
   assign vstep = (cfg.vert_step == '0) ? DIST_W'(1) : cfg.vert_step;
   assign hstep = (cfg.horz_step == '0) ? DIST_W'(1) : cfg.horz_step;

   // Once the accumulator drops below one, the click count is
   // (step - a) / step and the new accumulator is step minus the remainder.
   assign vdiv_arg = $signed({{(ACC_W - DIST_W){1'b0}}, vstep}) - va_ff;
   assign hdiv_arg = $signed({{(ACC_W - DIST_W){1'b0}}, hstep}) - ha_ff;

   function automatic axis_res_type finish_axis(input logic [DIR_W-1:0] dir_raw,
                                                input logic signed [ACC_W-1:0] a,
                                                input logic signed [ACC_W-1:0] acc,
                                                input logic [QUO_W-1:0] quo,
                                                input logic [DIST_W-1:0] rem,
                                                input logic [DIST_W-1:0] step);
      axis_res_type res;
      res.acc    = acc;
      res.clicks = '0;
      res.dir    = DIR_NONE;
      if (dir_raw != DIR_NONE) begin
         if (a < $signed(ACC_W'(1))) begin
            res.acc    = {{(ACC_W - DIST_W){1'b0}}, step} - {{(ACC_W - DIST_W){1'b0}}, rem};
            res.clicks = quo[CLK_W-1:0];
            res.dir    = dir_raw;
         end else begin
            res.acc = a;
         end
      end
      return res;
   endfunction

   bdse_div u_vdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (vdiv_arg[QUO_W-1:0]),
      .divisor   (vstep),
      .busy      (vbusy),
      .quotient  (vquo),
      .remainder (vrem)
   );

   bdse_div u_hdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (hdiv_arg[QUO_W-1:0]),
      .divisor   (hstep),
      .busy      (hbusy),
      .quotient  (hquo),
      .remainder (hrem)
   );

   assign vres = finish_axis(job_ff.vert.dir, va_ff, vacc_ff, vquo, vrem, vstep);
   assign hres = finish_axis(job_ff.horz.dir, ha_ff, hacc_ff, hquo, hrem, hstep);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      va_in        = va_ff;
      ha_in        = ha_ff;
      vacc_in      = vacc_ff;
      hacc_in      = hacc_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      vdir_in      = vdir_ff;
      vclk_in      = vclk_ff;
      hdir_in      = hdir_ff;
      hclk_in      = hclk_ff;
      warp_in      = warp_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_data;
               va_in    = vacc_ff - $signed({{(ACC_W - POS_W){1'b0}}, q_data.vert.moved});
               ha_in    = hacc_ff - $signed({{(ACC_W - POS_W){1'b0}}, q_data.horz.moved});
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (job_ff.op == OP_SCROLL) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_DIV: begin
            if (!vbusy && !hbusy) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               vdir_in      = DIR_NONE;
               vclk_in      = '0;
               hdir_in      = DIR_NONE;
               hclk_in      = '0;
               warp_in      = job_ff.warp;
               wx_in        = job_ff.warp_x;
               wy_in        = job_ff.warp_y;
               if (job_ff.op == OP_LOAD) begin
                  vacc_in = $signed({{(ACC_W - DIST_W){1'b0}}, cfg.vert_start_dist});
                  hacc_in = $signed({{(ACC_W - DIST_W){1'b0}}, cfg.horz_start_dist});
               end else if (job_ff.op == OP_SCROLL) begin
                  vacc_in = $signed(vres.acc);
                  hacc_in = $signed(hres.acc);
                  vdir_in = vres.dir;
                  vclk_in = vres.clicks;
                  hdir_in = hres.dir;
                  hclk_in = hres.clicks;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         vacc_ff      <= '0;
         hacc_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         vacc_ff      <= vacc_in;
         hacc_ff      <= hacc_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      va_ff   <= va_in;
      ha_ff   <= ha_in;
      vdir_ff <= vdir_in;
      vclk_ff <= vclk_in;
      hdir_ff <= hdir_in;
      hclk_ff <= hclk_in;
      warp_ff <= warp_in;
      wx_ff   <= wx_in;
      wy_ff   <= wy_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_vert_dir     = vdir_ff;
   assign rsp_vert_clicks  = vclk_ff;
   assign rsp_horz_dir     = hdir_ff;
   assign rsp_horz_clicks  = hclk_ff;
   assign rsp_warp_request = warp_ff;
   assign rsp_warp_x       = wx_ff;
   assign rsp_warp_y       = wy_ff;

endmodule

`default_nettype wire

[rtl/button_drag_scroll_emulator.sv]
// A scrolling motion request passes through the queue and then the back end's
// idle, prepare, divide and write states, the divide state waiting on the
// 17-step restoring divider of each axis; the back end takes the next request
// after writing. Press, release and all other requests skip the divide state.
// A four-entry queue lets requests keep arriving while the back end is busy.
// Synchronous active-high reset restores the register defaults, clears state.
`default_nettype none

module button_drag_scroll_emulator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wen,
   input  wire logic [bdse_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bdse_pkg::DIST_W-1:0]    csr_wdata,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [bdse_pkg::CMD_W-1:0]     req_command,
   input  wire logic [bdse_pkg::CODE_W-1:0]    req_code,
   input  wire logic [bdse_pkg::POS_W-1:0]     req_pos_x,
   input  wire logic [bdse_pkg::POS_W-1:0]     req_pos_y,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [bdse_pkg::DIR_W-1:0]          rsp_vert_dir,
   output logic [bdse_pkg::CLK_W-1:0]          rsp_vert_clicks,
   output logic [bdse_pkg::DIR_W-1:0]          rsp_horz_dir,
   output logic [bdse_pkg::CLK_W-1:0]          rsp_horz_clicks,
   output logic                                rsp_warp_request,
   output logic [bdse_pkg::POS_W-1:0]          rsp_warp_x,
   output logic [bdse_pkg::POS_W-1:0]          rsp_warp_y
);
   import bdse_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_push, q_pop, q_full, q_empty;
   job_type q_wdata, q_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_TRIGGER_CODE:    cfg_in.trigger_code    = csr_wdata[CODE_W-1:0];
            CSR_TOGGLE_MODE:     cfg_in.toggle_mode     = csr_wdata[0];
            CSR_TRAP_MODE:       cfg_in.trap_mode       = csr_wdata[0];
            CSR_INVERT_DIR:      cfg_in.invert_dir      = csr_wdata[0];
            CSR_VERT_START_DIST: cfg_in.vert_start_dist = csr_wdata;
            CSR_HORZ_START_DIST: cfg_in.horz_start_dist = csr_wdata;
            CSR_VERT_STEP:       cfg_in.vert_step       = csr_wdata;
            CSR_HORZ_STEP:       cfg_in.horz_step       = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = q_full;

   bdse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_push    (req_push),
      .req_command (req_command),
      .req_code    (req_code),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   bdse_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_rdata),
      .empty (q_empty)
   );

   bdse_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_data           (q_rdata),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_vert_dir     (rsp_vert_dir),
      .rsp_vert_clicks  (rsp_vert_clicks),
      .rsp_horz_dir     (rsp_horz_dir),
      .rsp_horz_clicks  (rsp_horz_clicks),
      .rsp_warp_request (rsp_warp_request),
      .rsp_warp_x       (rsp_warp_x),
      .rsp_warp_y       (rsp_warp_y)
   );

endmodule

`default_nettype wire

[rtl/bdse_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module bdse_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_empty,
   input wire logic                           rsp_pop,
   input wire logic [bdse_pkg::DIR_W-1:0]     rsp_vert_dir,
   input wire logic [bdse_pkg::CLK_W-1:0]     rsp_vert_clicks,
   input wire logic [bdse_pkg::DIR_W-1:0]     rsp_horz_dir,
   input wire logic [bdse_pkg::CLK_W-1:0]     rsp_horz_clicks,
   input wire logic                           rsp_warp_request,
   input wire logic [bdse_pkg::POS_W-1:0]     rsp_warp_x,
   input wire logic [bdse_pkg::POS_W-1:0]     rsp_warp_y
);
   import bdse_pkg::*;

   // No response may be pending right after reset.
   `BDSE_ASSERT_SAME(a_empty_after_reset, clock, reset, $fell(reset), rsp_empty)

   // A waiting response stays put until it is popped.
   `BDSE_ASSERT_NEXT(a_rsp_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_vert_clicks) && $stable(rsp_horz_clicks) && $stable(rsp_warp_request))

   // An axis without a direction carries no clicks.
   `BDSE_ASSERT_SAME(a_no_dir_no_clicks, clock, reset, !rsp_empty, (rsp_vert_dir != DIR_NONE || rsp_vert_clicks == '0) && (rsp_horz_dir != DIR_NONE || rsp_horz_clicks == '0))

   // Warp coordinates are zero unless a warp is requested.
   `BDSE_ASSERT_SAME(a_warp_fields, clock, reset, !rsp_empty && !rsp_warp_request, rsp_warp_x == '0 && rsp_warp_y == '0)

endmodule

bind button_drag_scroll_emulator bdse_checker u_bdse_checker (.*);

`default_nettype wire

[test/button_drag_scroll_emulator_tb.sv]
`default_nettype none

module button_drag_scroll_emulator_tb;
   import bdse_pkg::*;

   localparam logic [CMD_W-1:0] CMD_OTHER = 2'd3;
   localparam int STALL_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 25;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [DIR_W-1:0] vert_dir;
      logic [CLK_W-1:0] vert_clicks;
      logic [DIR_W-1:0] horz_dir;
      logic [CLK_W-1:0] horz_clicks;
      logic             warp_request;
      logic [POS_W-1:0] warp_x;
      logic [POS_W-1:0] warp_y;
   } wheel_report_type;

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 csr_wen     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [DIST_W-1:0]    csr_wdata   = '0;
   logic                 req_push    = 1'b0;
   logic                 req_full;
   logic [CMD_W-1:0]     req_command = '0;
   logic [CODE_W-1:0]    req_code    = '0;
   logic [POS_W-1:0]     req_pos_x   = '0;
   logic [POS_W-1:0]     req_pos_y   = '0;
   logic                 rsp_empty;
   logic                 rsp_pop     = 1'b0;
   logic [DIR_W-1:0]     rsp_vert_dir;
   logic [CLK_W-1:0]     rsp_vert_clicks;
   logic [DIR_W-1:0]     rsp_horz_dir;
   logic [CLK_W-1:0]     rsp_horz_clicks;
   logic                 rsp_warp_request;
   logic [POS_W-1:0]     rsp_warp_x;
   logic [POS_W-1:0]     rsp_warp_y;

   // Shadow copy of the block's registers and drag state.
   cfg_type          cfg         = CFG_RESET;
   logic             drag_active = 1'b0;
   logic [POS_W-1:0] anchor_x    = '0;
   logic [POS_W-1:0] anchor_y    = '0;
   logic [POS_W-1:0] last_x      = '0;
   logic [POS_W-1:0] last_y      = '0;
   int               vert_acc    = 0;
   int               horz_acc    = 0;

   wheel_report_type expected_reports[$];
   int               fault_count     = 0;
   bit               bursts_on       = 1'b1;
   int               rsp_hold_cycles = 0;

   button_drag_scroll_emulator DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_code         (req_code),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_vert_dir     (rsp_vert_dir),
      .rsp_vert_clicks  (rsp_vert_clicks),
      .rsp_horz_dir     (rsp_horz_dir),
      .rsp_horz_clicks  (rsp_horz_clicks),
      .rsp_warp_request (rsp_warp_request),
      .rsp_warp_x       (rsp_warp_x),
      .rsp_warp_y       (rsp_warp_y)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Takes a movement off an accumulator and returns the clicks it pays for;
   // each click adds one step back until the accumulator is at least 1.
   function automatic int pay_clicks(inout int acc, input int moved, input int step);
      int remain;
      int unit;
      int clicks;
      remain = acc - moved;
      unit   = (step == 0) ? 1 : step;
      clicks = 0;
      if (remain < 1) begin
         clicks = (unit - remain) / unit;
         remain = remain + clicks * unit;
      end
      acc = remain;
      return clicks;
   endfunction

   function automatic void wheel_axis(inout int acc, input int from, input int to,
                                      input int step, output logic [DIR_W-1:0] dir,
                                      output logic [CLK_W-1:0] clicks);
      int               count;
      logic [DIR_W-1:0] way;
      count = 0;
      way   = DIR_NONE;
      if (to < from) begin
         count = pay_clicks(acc, from - to, step);
         way   = cfg.invert_dir ? DIR_POS : DIR_NEG;
      end else if (to > from) begin
         count = pay_clicks(acc, to - from, step);
         way   = cfg.invert_dir ? DIR_NEG : DIR_POS;
      end
      clicks = count[CLK_W-1:0];
      dir    = (count != 0) ? way : DIR_NONE;
   endfunction

   function automatic wheel_report_type predict_wheel(input logic [CMD_W-1:0] cmd,
                                                      input logic [CODE_W-1:0] code,
                                                      input logic [POS_W-1:0] x,
                                                      input logic [POS_W-1:0] y);
      wheel_report_type r;
      logic [DIR_W-1:0] vdir;
      logic [DIR_W-1:0] hdir;
      logic [CLK_W-1:0] vclk;
      logic [CLK_W-1:0] hclk;
      r = '0;
      case (cmd)
         CMD_PRESS: begin
            if (code == cfg.trigger_code) begin
               anchor_x    = x;
               anchor_y    = y;
               drag_active = cfg.toggle_mode ? !drag_active : 1'b1;
               vert_acc    = int'(cfg.vert_start_dist);
               horz_acc    = int'(cfg.horz_start_dist);
            end
         end
         CMD_RELEASE: begin
            if (code == cfg.trigger_code && !cfg.toggle_mode)
               drag_active = 1'b0;
         end
         CMD_MOTION: begin
            if (drag_active && (x != anchor_x || y != anchor_y)) begin
               if (cfg.trap_mode) begin
                  r.warp_request = 1'b1;
                  r.warp_x       = anchor_x;
                  r.warp_y       = anchor_y;
               end
               wheel_axis(vert_acc, int'(last_y), int'(y), int'(cfg.vert_step), vdir, vclk);
               wheel_axis(horz_acc, int'(last_x), int'(x), int'(cfg.horz_step), hdir, hclk);
               r.vert_dir    = vdir;
               r.vert_clicks = vclk;
               r.horz_dir    = hdir;
               r.horz_clicks = hclk;
            end
            last_x = x;
            last_y = y;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offers one request and returns at the edge that accepts it, with push
   // still high so that the next request can follow without a bubble.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                               input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
      bit taken;
      if (bursts_on && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_command <= cmd;
      req_code    <= code;
      req_pos_x   <= x;
      req_pos_y   <= y;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if (!req_full) begin
            taken = 1'b1;
            expected_reports.push_back(predict_wheel(cmd, code, x, y));
         end
         @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIST_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_TRIGGER_CODE:    cfg.trigger_code    = value[CODE_W-1:0];
         CSR_TOGGLE_MODE:     cfg.toggle_mode     = value[0];
         CSR_TRAP_MODE:       cfg.trap_mode       = value[0];
         CSR_INVERT_DIR:      cfg.invert_dir      = value[0];
         CSR_VERT_START_DIST: cfg.vert_start_dist = value;
         CSR_HORZ_START_DIST: cfg.horz_start_dist = value;
         CSR_VERT_STEP:       cfg.vert_step       = value;
         CSR_HORZ_STEP:       cfg.horz_step       = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Narrow registers get random upper bits, which the block must ignore.
   task automatic apply_setting(input cfg_type c);
      logic [DIST_W-1:0] junk;
      junk = DIST_W'($urandom);
      write_csr(CSR_TRIGGER_CODE, {junk[DIST_W-1:CODE_W], c.trigger_code});
      junk = DIST_W'($urandom);
      write_csr(CSR_TOGGLE_MODE, {junk[DIST_W-1:1], c.toggle_mode});
      junk = DIST_W'($urandom);
      write_csr(CSR_TRAP_MODE, {junk[DIST_W-1:1], c.trap_mode});
      junk = DIST_W'($urandom);
      write_csr(CSR_INVERT_DIR, {junk[DIST_W-1:1], c.invert_dir});
      write_csr(CSR_VERT_START_DIST, c.vert_start_dist);
      write_csr(CSR_HORZ_START_DIST, c.horz_start_dist);
      write_csr(CSR_VERT_STEP, c.vert_step);
      write_csr(CSR_HORZ_STEP, c.horz_step);
   endtask

   // Mostly small values so that clicks come often, now and then an extreme.
   function automatic logic [DIST_W-1:0] pick_distance(input int lo, input int hi);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return DIST_W'($urandom);
         default: return DIST_W'($urandom_range(lo, hi));
      endcase
   endfunction

   function automatic cfg_type random_setting();
      cfg_type c;
      c.trigger_code    = ($urandom_range(0, 3) == 0) ? 8'd2 : 8'($urandom);
      c.toggle_mode     = 1'($urandom_range(0, 1));
      c.trap_mode       = 1'($urandom_range(0, 1));
      c.invert_dir      = 1'($urandom_range(0, 1));
      c.vert_start_dist = pick_distance(0, 100);
      c.horz_start_dist = pick_distance(0, 100);
      c.vert_step       = pick_distance(1, 60);
      c.horz_step       = pick_distance(1, 60);
      return c;
   endfunction

   function automatic logic [POS_W-1:0] jitter_pos(input logic [POS_W-1:0] p);
      int v;
      v = $urandom_range(0, 80);
      v = v - 40 + int'(p);
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      return v[POS_W-1:0];
   endfunction

   // Drag gestures (press, a run of motions, usually a release) with random
   // requests of any kind mixed in. Requests of the unused command are not counted.
   task automatic run_drag_traffic(input int count);
      int                sent;
      int                moves;
      logic [POS_W-1:0]  ax;
      logic [POS_W-1:0]  ay;
      logic [POS_W-1:0]  px;
      logic [POS_W-1:0]  py;
      logic [CMD_W-1:0]  cmd;
      logic [CODE_W-1:0] code;
      sent = 0;
      px   = POS_W'($urandom);
      py   = POS_W'($urandom);
      while (sent < count) begin
         if ($urandom_range(0, 4) == 0) begin
            cmd  = CMD_W'($urandom);
            code = ($urandom_range(0, 2) == 0) ? cfg.trigger_code : 8'($urandom);
            px   = POS_W'($urandom);
            py   = POS_W'($urandom);
            send_request(cmd, code, px, py);
            if (cmd != CMD_OTHER) sent++;
         end else begin
            ax = ($urandom_range(0, 3) == 0) ? 15'($urandom) : jitter_pos(px);
            ay = ($urandom_range(0, 3) == 0) ? 15'($urandom) : jitter_pos(py);
            send_request(CMD_PRESS, cfg.trigger_code, ax, ay);
            moves = $urandom_range(1, 12);
            sent  = sent + moves + 1;
            repeat (moves) begin
               case ($urandom_range(0, 9))
                  0: begin
                     px = ax;
                     py = ay;
                  end
                  1: begin
                     px = POS_W'($urandom);
                     py = POS_W'($urandom);
                  end
                  default: begin
                     px = jitter_pos(px);
                     py = jitter_pos(py);
                  end
               endcase
               code = CODE_W'($urandom);
               send_request(CMD_MOTION, code, px, py);
            end
            if ($urandom_range(0, 5) != 0) begin
               send_request(CMD_RELEASE, cfg.trigger_code, px, py);
               sent++;
            end
         end
      end
   endtask

   task automatic test_reset_defaults();
      send_request(CMD_MOTION, 8'd0, 15'd5, 15'd5);
      send_request(CMD_PRESS, 8'd3, 15'd40, 15'd40);
      send_request(CMD_PRESS, 8'd2, 15'd0, 15'd0);
      send_request(CMD_MOTION, 8'd255, 15'd32767, 15'd32767);
      send_request(CMD_MOTION, 8'd0, 15'd0, 15'd0);
      send_request(CMD_MOTION, 8'd0, 15'd0, 15'd20);
      send_request(CMD_OTHER, 8'd255, 15'd32767, 15'd0);
      send_request(CMD_RELEASE, 8'd255, 15'd0, 15'd0);
      send_request(CMD_RELEASE, 8'd2, 15'd0, 15'd0);
      // Leaves the last y at zero, so the next drag can owe the most clicks.
      send_request(CMD_MOTION, 8'd0, 15'd100, 15'd0);
      wait_idle();
   endtask

   task automatic test_option_extremes();
      cfg_type c;
      // Toggle, trap and invert on, zero step treated as one.
      c = '{trigger_code: 8'd255, toggle_mode: 1'b1, trap_mode: 1'b1, invert_dir: 1'b1,
            vert_start_dist: 16'd0, horz_start_dist: 16'hFFFF,
            vert_step: 16'd0, horz_step: 16'hFFFF};
      apply_setting(c);
      send_request(CMD_PRESS, 8'd255, 15'd32767, 15'd0);
      send_request(CMD_MOTION, 8'd0, 15'd0, 15'd32767);
      send_request(CMD_RELEASE, 8'd255, 15'd0, 15'd32767);
      send_request(CMD_MOTION, 8'd0, 15'd32767, 15'd0);
      send_request(CMD_MOTION, 8'd0, 15'd1, 15'd1);
      send_request(CMD_PRESS, 8'd255, 15'd5, 15'd5);
      send_request(CMD_MOTION, 8'd0, 15'd9, 15'd9);
      send_request(CMD_PRESS, 8'd0, 15'd9, 15'd9);
      wait_idle();
      c = '{trigger_code: 8'd0, toggle_mode: 1'b0, trap_mode: 1'b0, invert_dir: 1'b0,
            vert_start_dist: 16'hFFFF, horz_start_dist: 16'd0,
            vert_step: 16'hFFFF, horz_step: 16'd1};
      apply_setting(c);
      send_request(CMD_PRESS, 8'd0, 15'd16383, 15'd16383);
      send_request(CMD_MOTION, 8'd0, 15'd0, 15'd32767);
      send_request(CMD_MOTION, 8'd0, 15'd32767, 15'd0);
      send_request(CMD_RELEASE, 8'd0, 15'd32767, 15'd0);
      wait_idle();
   endtask

   task automatic test_random_settings();
      repeat (6) begin
         apply_setting(random_setting());
         run_drag_traffic(105);
         wait_idle();
      end
   endtask

   // The receiver holds off while a long drag is offered, so the block fills
   // up and has to refuse requests for a while.
   task automatic test_full_backpressure();
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      apply_setting(CFG_RESET);
      bursts_on       = 1'b0;
      rsp_hold_cycles = 300;
      px = 15'd1000;
      py = 15'd1000;
      send_request(CMD_PRESS, cfg.trigger_code, px, py);
      repeat (20) begin
         px = jitter_pos(px);
         py = jitter_pos(py);
         send_request(CMD_MOTION, 8'd0, px, py);
      end
      send_request(CMD_RELEASE, cfg.trigger_code, px, py);
      wait_idle();
      bursts_on = 1'b1;
   endtask

   task automatic test_steady_stream();
      apply_setting(random_setting());
      bursts_on = 1'b0;
      run_drag_traffic(80);
      wait_idle();
   endtask

   initial begin : rsp_receiver
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            stall = $urandom_range(1, 12) - 1;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Outputs are sampled at the falling edge, where they are settled.
   always @(negedge clock) begin : check_reports
      wheel_report_type seen;
      wheel_report_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         seen = {rsp_vert_dir, rsp_vert_clicks, rsp_horz_dir, rsp_horz_clicks,
                 rsp_warp_request, rsp_warp_x, rsp_warp_y};
         if (expected_reports.size() == 0) begin
            if (fault_count < REPORT_LIMIT)
               $display("unexpected response: vdir %0d vclk %0d hdir %0d hclk %0d",
                        seen.vert_dir, seen.vert_clicks, seen.horz_dir, seen.horz_clicks);
            fault_count++;
         end else begin
            want = expected_reports.pop_front();
            if (seen !== want) begin
               if (fault_count < REPORT_LIMIT) begin
                  $display("mismatch: expected vdir %0d vclk %0d hdir %0d hclk %0d warp %0d %0d %0d",
                           want.vert_dir, want.vert_clicks, want.horz_dir, want.horz_clicks,
                           want.warp_request, want.warp_x, want.warp_y);
                  $display("          actual   vdir %0d vclk %0d hdir %0d hclk %0d warp %0d %0d %0d",
                           seen.vert_dir, seen.vert_clicks, seen.horz_dir, seen.horz_clicks,
                           seen.warp_request, seen.warp_x, seen.warp_y);
               end
               fault_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(negedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet = 0;
         else
            quiet++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_option_extremes();
      test_random_settings();
      test_full_backpressure();
      test_steady_stream();
      if (fault_count == 0 && expected_reports.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
